FILE: hdl/lru_page_frame_replacer_core_macros.svh
// ----------------------------------------------------------------------------
// lru page frame replacer assertion macros
// shared concurrent assertion forms used by the block's modules
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_FRAME_REPLACER_CORE_MACROS_SVH
`define LRU_PAGE_FRAME_REPLACER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LRU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru assertion failed");

// next-cycle implication, disabled during reset
`define LRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru assertion failed");

`endif

FILE: hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru package
// sizes, types and control structs shared by the lru replacer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_pkg;

   localparam int FRAMES  = 10;
   localparam int PAGE_W  = 10;
   localparam int IDX_W   = $clog2(FRAMES);
   localparam int RANK_W  = $clog2(FRAMES);
   localparam int LIMIT_W = $clog2(FRAMES + 1);

   localparam int REQ_TDATA_W = ((PAGE_W + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + IDX_W + 1 + PAGE_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [PAGE_W-1:0]  page_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [LIMIT_W-1:0] limit_type;

   localparam rank_type RANK_MAX = RANK_W'(FRAMES - 1);

   // controller to datapath commands
   typedef struct packed {
      logic load;    // latch the request beat
      logic eval;    // lookup, free search and victim pick
      logic commit;  // apply frame and rank update, load result register
   } cmd_type;

   // result beat, hit in the lowest bit
   typedef struct packed {
      page_type evicted_page;
      logic     evicted_valid;
      idx_type  frame;
      logic     hit;
   } rsp_type;

endpackage

FILE: hdl/lru_ctrl.sv
// ----------------------------------------------------------------------------
// lru controller
// sequences one request through load, evaluate and commit, owns rsp valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_page_frame_replacer_core_macros.svh"

module lru_ctrl
   import lru_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // result register must be empty or draining this cycle
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LRU_ASSERT_NOW(a_commit_out_free, clock, reset, cmd.commit, out_free)
   `LRU_ASSERT_NEXT(a_commit_gives_beat, clock, reset, cmd.commit, rsp_valid_ff)
   `LRU_ASSERT_NEXT(a_load_then_eval, clock, reset, cmd.load, cmd.eval)

endmodule

FILE: hdl/lru_dp.sv
// ----------------------------------------------------------------------------
// lru datapath
// frame table, valid bits, recency ranks, lookup and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_page_frame_replacer_core_macros.svh"

module lru_dp
   import lru_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  page_type req_page,
   output rsp_type  rsp_data
);

   page_type           page_ff, page_in;
   logic [FRAMES-1:0]  valid_ff, valid_in;
   page_type           page_tab_ff [FRAMES];
   page_type           page_tab_in [FRAMES];
   rank_type           rank_ff [FRAMES];
   rank_type           rank_in [FRAMES];
   logic               hit_ff, hit_in;
   logic               evict_ff, evict_in;
   idx_type            tgt_ff, tgt_in;
   limit_type          limit_ff, limit_in;
   rsp_type            out_ff, out_in;

   logic [FRAMES-1:0]  match;
   logic [FRAMES-1:0]  free;
   logic [FRAMES-1:0]  oldest;
   idx_type            hit_idx, free_idx, old_idx;

   // lowest set bit index
   function automatic idx_type first_set(input logic [FRAMES-1:0] v);
      idx_type r;
      r = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   // lookup: ranks of a full table are a permutation, so the lru frame
   // is the one holding the top rank
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         match[i]  = valid_ff[i] && (page_tab_ff[i] == page_ff);
         free[i]   = !valid_ff[i];
         oldest[i] = (rank_ff[i] == RANK_MAX);
      end
      hit_idx  = first_set(match);
      free_idx = first_set(free);
      old_idx  = first_set(oldest);
   end

   always_comb begin
      page_in  = page_ff;
      hit_in   = hit_ff;
      evict_in = evict_ff;
      tgt_in   = tgt_ff;
      limit_in = limit_ff;
      if (cmd.load) begin
         page_in = req_page;
      end
      if (cmd.eval) begin
         hit_in   = |match;
         evict_in = !(|match) && !(|free);
         if (|match) begin
            tgt_in   = hit_idx;
            limit_in = LIMIT_W'(rank_ff[hit_idx]);
         end else begin
            tgt_in   = (|free) ? free_idx : old_idx;
            limit_in = LIMIT_W'(FRAMES);
         end
      end
   end

   // commit: target becomes most recent, younger valid frames age by one
   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      for (int i = 0; i < FRAMES; i++) begin
         rank_in[i]     = rank_ff[i];
         page_tab_in[i] = page_tab_ff[i];
      end
      if (cmd.commit) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (IDX_W'(i) == tgt_ff) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
               if (!hit_ff) begin
                  page_tab_in[i] = page_ff;
               end
            end else if (valid_ff[i] && (LIMIT_W'(rank_ff[i]) < limit_ff) &&
                         (rank_ff[i] != RANK_MAX)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         out_in.hit           = hit_ff;
         out_in.frame         = tgt_ff;
         out_in.evicted_valid = evict_ff;
         out_in.evicted_page  = evict_ff ? page_tab_ff[tgt_ff] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      hit_ff   <= hit_in;
      evict_ff <= evict_in;
      tgt_ff   <= tgt_in;
      limit_ff <= limit_in;
      out_ff   <= out_in;
      for (int i = 0; i < FRAMES; i++) begin
         page_tab_ff[i] <= page_tab_in[i];
      end
   end

   assign rsp_data = out_ff;

   `LRU_ASSERT_NEXT(a_target_valid, clock, reset, cmd.commit, valid_ff[$past(tgt_ff)])
   `LRU_ASSERT_NOW(a_evict_full, clock, reset, cmd.commit && evict_ff, &valid_ff)
   `LRU_ASSERT_NOW(a_fill_free, clock, reset, cmd.commit && !hit_ff && !evict_ff,
      !valid_ff[tgt_ff])

endmodule

FILE: hdl/lru_page_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru page frame replacer core
// fully associative page frame table with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage:
//   req channel: one beat per page reference, page number in the low bits.
//   rsp channel: one beat per request with hit, frame index, evicted flag
//   and evicted page (zero when nothing was replaced).
//   each request passes through three steps: accept, evaluate (parallel tag
//   compare, free-frame and lru-frame priority pick, all against the
//   registered table), then commit (table and rank update plus result
//   register load). a result appears in the cycle after commit. a new
//   request is accepted only once the previous one has committed.
//   the result register decouples the sides: the next request is accepted
//   while a result waits; if the receiver stalls, commit waits until the
//   result register is empty or draining, and req_tready stays low.
//   reset clears every valid bit and rank at once: all frames free, no
//   clearing pass, and the block accepts on the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_frame_replacer_core
   import lru_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // page
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // hit, frame, evicted_valid, evicted_page
);

   cmd_type cmd;
   rsp_type rsp_data;

   lru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lru_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_page (req_tdata[PAGE_W-1:0]),
      .rsp_data (rsp_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_data);

endmodule

FILE: tb/lru_page_frame_replacer_core_test.sv
// ----------------------------------------------------------------------------
// lru page frame replacer core testbench
// streams page references into the replacer and compares every response beat
// with a behavioral frame table that tracks pages, valid bits and lru ranks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_frame_replacer_core_test;
   import lru_pkg::*;

   localparam int IDLE_LIMIT = 5000;  // cycles without any beat before giving up
   localparam int DRAIN_WAIT = 8;     // block latency plus margin

   // frame table prediction and queue of responses still to come
   class lru_table_scoreboard;
      page_type held_page [FRAMES];
      bit       held_valid[FRAMES];
      rank_type age       [FRAMES];
      rsp_type  expected_rsp[$];
      int       errors;

      function new();
         for (int i = 0; i < FRAMES; i++) begin
            held_page[i]  = '0;
            held_valid[i] = 1'b0;
            age[i]        = '0;
         end
         errors = 0;
      endfunction

      // ages valid frames ranked below the limit, never past the oldest rank
      function void age_frames(int limit);
         for (int i = 0; i < FRAMES; i++) begin
            if (held_valid[i] && int'(age[i]) < limit && age[i] < RANK_MAX)
               age[i] = age[i] + 1'b1;
         end
      endfunction

      function void note_request(page_type page);
         rsp_type rsp;
         int      slot;
         int      free_slot;
         bit      found;
         bit      free_found;
         rank_type oldest;
         found      = 1'b0;
         free_found = 1'b0;
         slot       = 0;
         free_slot  = 0;
         rsp        = '0;
         for (int i = 0; i < FRAMES; i++) begin
            if (held_valid[i] && held_page[i] == page && !found) begin
               found = 1'b1;
               slot  = i;
            end
            if (!held_valid[i] && !free_found) begin
               free_found = 1'b1;
               free_slot  = i;
            end
         end
         if (found) begin
            rsp.hit = 1'b1;
            age_frames(int'(age[slot]));
         end else if (free_found) begin
            slot = free_slot;
            age_frames(FRAMES);
         end else begin
            // victim: largest rank, lowest index on a tie
            oldest = '0;
            slot   = 0;
            for (int i = 0; i < FRAMES; i++) begin
               if (age[i] > oldest) begin
                  oldest = age[i];
                  slot   = i;
               end
            end
            rsp.evicted_valid = 1'b1;
            rsp.evicted_page  = held_page[slot];
            held_valid[slot]  = 1'b0;
            age_frames(FRAMES);
         end
         held_page[slot]  = page;
         held_valid[slot] = 1'b1;
         age[slot]        = '0;
         rsp.frame        = idx_type'(slot);
         expected_rsp.insert(expected_rsp.size(), rsp);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, got);
            errors++;
            return;
         end
         want = expected_rsp[0];
         expected_rsp.delete(0);
         if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            errors++;
         end
         if (got.frame !== want.frame) begin
            $display("%0t: frame expected %0d actual %0d", $time, want.frame, got.frame);
            errors++;
         end
         if (got.evicted_valid !== want.evicted_valid) begin
            $display("%0t: evicted_valid expected %0b actual %0b", $time,
                     want.evicted_valid, got.evicted_valid);
            errors++;
         end
         if (got.evicted_page !== want.evicted_page) begin
            $display("%0t: evicted_page expected %0d actual %0d", $time,
                     want.evicted_page, got.evicted_page);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // page
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // hit, frame, evicted_valid, evicted_page

   lru_table_scoreboard sb = new();
   bit idle_on = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;
   page_type page_pool[$];
   page_type last_page = '0;

   always #5 clock = ~clock;

   lru_page_frame_replacer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_page(page_type page);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(page);
      do @(posedge clock); while (!req_tready);
      sb.note_request(page);
      last_page = page;
   endtask

   // random page: mostly from a small working set so hits and evictions occur
   function automatic page_type pick_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return page_pool[$urandom_range(0, page_pool.size() - 1)];
      if (r < 85)
         return last_page;
      return page_type'($urandom_range(0, (1 << PAGE_W) - 1));
   endfunction

   // response side: check accepted beats, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_type'(rsp_tdata[RSP_BITS-1:0]));
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on)
            stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      page_type directed[$];
      int pool_size;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // extremes, a repeat hit on page 0, fill all ten, then hits and
      // evictions against a full table
      directed = '{10'd0, 10'd1023, 10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5,
                   10'd6, 10'd7, 10'd8, 10'd1023, 10'd512, 10'd512, 10'd1,
                   10'd341, 10'd682, 10'd0, 10'd2, 10'd3, 10'd1023, 10'd4,
                   10'd5, 10'd6, 10'd7};
      foreach (directed[i])
         send_page(directed[i]);

      for (int chunk = 0; chunk < 8; chunk++) begin
         idle_on   = (chunk % 4) != 1;
         pool_size = $urandom_range(6, 16);
         page_pool.delete();
         for (int i = 0; i < pool_size; i++)
            page_pool.insert(page_pool.size(),
                             page_type'($urandom_range(0, (1 << PAGE_W) - 1)));
         for (int n = 0; n < 50; n++)
            send_page(pick_page());
      end
      req_tvalid <= 1'b0;

      while (sb.expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: lru_page_frame_replacer_core.f
+incdir+hdl
hdl/lru_pkg.sv
hdl/lru_ctrl.sv
hdl/lru_dp.sv
hdl/lru_page_frame_replacer_core.sv
tb/lru_page_frame_replacer_core_test.sv
